// ===== sv/dcbp_pkg.sv =====
// Shared types, constants and codes of the display command byte parser.
`default_nettype none

package dcbp_pkg;

  localparam int CLEAR_WIDTH_DEF = 16;
  localparam int GLYPH_ROWS_DEF  = 8;
  localparam int MAX_ROWS        = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OP_SET_CURSOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_WRITE_RUN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_BRIGHTNESS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_DEFINE_GLYPH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_CLEAR_LINE   = 3'd4;

  // Opcode reset values.
  localparam logic [7:0] OP_SET_CURSOR_RST   = 8'd1;
  localparam logic [7:0] OP_WRITE_RUN_RST    = 8'd2;
  localparam logic [7:0] OP_BRIGHTNESS_RST   = 8'd3;
  localparam logic [7:0] OP_DEFINE_GLYPH_RST = 8'd4;
  localparam logic [7:0] OP_CLEAR_LINE_RST   = 8'd5;

  // Result action codes.
  localparam logic [1:0] ACT_PUT_CHAR = 2'd0;
  localparam logic [1:0] ACT_BRIGHT   = 2'd1;
  localparam logic [1:0] ACT_GLYPH    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CURSOR,
    ST_COUNT,
    ST_CHARS,
    ST_BRIGHT,
    ST_GLYPH_ID,
    ST_GLYPH_ROWS,
    ST_CLEAR
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_BRIGHT,
    KIND_GLYPH,
    KIND_CLEAR
  } cmd_kind_t;

  // One classified command waiting for the back end.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  column;
    logic [7:0]  data;
    logic [63:0] bitmap;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/dcbp_front.sv =====
// Front end: opcode registers, byte parser and command classification.
`default_nettype none

module dcbp_front
  import dcbp_pkg::*;
#(
  parameter int CLEAR_WIDTH = CLEAR_WIDTH_DEF,
  parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_accept,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      push,
  output cmd_t                      push_cmd
);

  logic [7:0]   op_cursor_r, op_write_r, op_bright_r, op_glyph_r, op_clear_r;
  parse_state_t state_r, state_nxt;
  logic [7:0]   cursor_r, cursor_nxt;
  logic [7:0]   remain_r, remain_nxt;
  logic [7:0]   glyph_id_r, glyph_id_nxt;
  logic [2:0]   row_cnt_r, row_cnt_nxt;
  logic [7:0]   rows_r [MAX_ROWS];
  logic         last_row;
  logic [63:0]  bitmap;

  assign last_row = ({1'b0, row_cnt_r} == 4'(GLYPH_ROWS - 1));

  // The current byte stands in for the row that is being received.
  always_comb begin
    bitmap = '0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      if (r < GLYPH_ROWS) begin
        bitmap[8*r +: 8] = (row_cnt_r == 3'(r)) ? in_rx_byte : rows_r[r];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      case (state_r)
        ST_IDLE: begin
          if (in_rx_byte == op_cursor_r) begin
            state_nxt = ST_CURSOR;
          end else if (in_rx_byte == op_write_r) begin
            state_nxt = ST_COUNT;
          end else if (in_rx_byte == op_bright_r) begin
            state_nxt = ST_BRIGHT;
          end else if (in_rx_byte == op_glyph_r) begin
            state_nxt = ST_GLYPH_ID;
          end else if (in_rx_byte == op_clear_r) begin
            state_nxt = ST_CLEAR;
          end
        end
        ST_CURSOR:     state_nxt = ST_IDLE;
        ST_COUNT:      state_nxt = ST_CHARS;
        ST_CHARS:      state_nxt = (remain_r == 8'd1) ? ST_IDLE : ST_CHARS;
        ST_BRIGHT:     state_nxt = ST_IDLE;
        ST_GLYPH_ID:   state_nxt = ST_GLYPH_ROWS;
        ST_GLYPH_ROWS: state_nxt = last_row ? ST_IDLE : ST_GLYPH_ROWS;
        ST_CLEAR:      state_nxt = ST_IDLE;
        default:       state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    push         = 1'b0;
    push_cmd     = '0;
    cursor_nxt   = cursor_r;
    remain_nxt   = remain_r;
    glyph_id_nxt = glyph_id_r;
    row_cnt_nxt  = row_cnt_r;
    if (in_accept) begin
      case (state_r)
        ST_CURSOR: cursor_nxt = in_rx_byte;
        ST_COUNT:  remain_nxt = in_rx_byte;
        ST_CHARS: begin
          push            = 1'b1;
          push_cmd.kind   = KIND_PUT;
          push_cmd.column = cursor_r;
          push_cmd.data   = in_rx_byte;
          cursor_nxt      = cursor_r + 8'd1;
          remain_nxt      = remain_r - 8'd1;
        end
        ST_BRIGHT: begin
          push          = 1'b1;
          push_cmd.kind = KIND_BRIGHT;
          push_cmd.data = in_rx_byte;
        end
        ST_GLYPH_ID: glyph_id_nxt = in_rx_byte;
        ST_GLYPH_ROWS: begin
          if (last_row) begin
            push            = 1'b1;
            push_cmd.kind   = KIND_GLYPH;
            push_cmd.data   = glyph_id_r;
            push_cmd.bitmap = bitmap;
            row_cnt_nxt     = 3'd0;
          end else begin
            row_cnt_nxt = row_cnt_r + 3'd1;
          end
        end
        ST_CLEAR: begin
          push          = 1'b1;
          push_cmd.kind = KIND_CLEAR;
          cursor_nxt    = 8'(CLEAR_WIDTH);
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cursor_r <= OP_SET_CURSOR_RST;
      op_write_r  <= OP_WRITE_RUN_RST;
      op_bright_r <= OP_BRIGHTNESS_RST;
      op_glyph_r  <= OP_DEFINE_GLYPH_RST;
      op_clear_r  <= OP_CLEAR_LINE_RST;
      state_r     <= ST_IDLE;
      cursor_r    <= 8'd0;
      remain_r    <= 8'd0;
      row_cnt_r   <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OP_SET_CURSOR:   op_cursor_r <= cfg_wdata;
          CFG_OP_WRITE_RUN:    op_write_r  <= cfg_wdata;
          CFG_OP_BRIGHTNESS:   op_bright_r <= cfg_wdata;
          CFG_OP_DEFINE_GLYPH: op_glyph_r  <= cfg_wdata;
          CFG_OP_CLEAR_LINE:   op_clear_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      remain_r  <= remain_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_id_r <= glyph_id_nxt;
    if (in_accept && state_r == ST_GLYPH_ROWS) begin
      rows_r[row_cnt_r] <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dcbp_queue.sv =====
// Small command queue between the front end and the back end.
`default_nettype none

module dcbp_queue
  import dcbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dcbp_back.sv =====
// Back end: expands queued commands into result transactions in an output register.
`default_nettype none

module dcbp_back
  import dcbp_pkg::*;
#(
  parameter int CLEAR_WIDTH = CLEAR_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire cmd_t        head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_action,
  output logic [7:0]       out_column,
  output logic [7:0]       out_char_code,
  output logic [7:0]       out_brightness_level,
  output logic [7:0]       out_glyph_index,
  output logic [63:0]      out_glyph_bitmap,
  output logic             out_last
);

  localparam int CNT_W = (CLEAR_WIDTH > 1) ? $clog2(CLEAR_WIDTH) : 1;

  logic             valid_r;
  logic [CNT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             load;
  logic             clr_final;
  logic [1:0]       action_nxt, action_r;
  logic [7:0]       column_nxt, column_r;
  logic [7:0]       char_nxt, char_r;
  logic [7:0]       bright_nxt, bright_r;
  logic [7:0]       gid_nxt, gid_r;
  logic [63:0]      bitmap_nxt, bitmap_r;
  logic             last_nxt, last_r;

  assign load      = head_valid && (!valid_r || out_ready);
  assign clr_final = (clr_cnt_r == CNT_W'(CLEAR_WIDTH - 1));

  // A clear command stays at the head until its final space is loaded.
  always_comb begin
    action_nxt  = ACT_PUT_CHAR;
    column_nxt  = 8'd0;
    char_nxt    = 8'd0;
    bright_nxt  = 8'd0;
    gid_nxt     = 8'd0;
    bitmap_nxt  = '0;
    last_nxt    = 1'b1;
    pop         = load;
    clr_cnt_nxt = clr_cnt_r;
    case (head_cmd.kind)
      KIND_PUT: begin
        column_nxt = head_cmd.column;
        char_nxt   = head_cmd.data;
      end
      KIND_BRIGHT: begin
        action_nxt = ACT_BRIGHT;
        bright_nxt = head_cmd.data;
      end
      KIND_GLYPH: begin
        action_nxt = ACT_GLYPH;
        gid_nxt    = head_cmd.data;
        bitmap_nxt = head_cmd.bitmap;
      end
      KIND_CLEAR: begin
        column_nxt = 8'(clr_cnt_r);
        char_nxt   = SPACE_CODE;
        last_nxt   = clr_final;
        pop        = load && clr_final;
        if (load) begin
          clr_cnt_nxt = clr_final ? '0 : clr_cnt_r + 1'b1;
        end
      end
      default: begin
        last_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      if (!valid_r || out_ready) begin
        valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r <= action_nxt;
      column_r <= column_nxt;
      char_r   <= char_nxt;
      bright_r <= bright_nxt;
      gid_r    <= gid_nxt;
      bitmap_r <= bitmap_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_action           = action_r;
  assign out_column           = column_r;
  assign out_char_code        = char_r;
  assign out_brightness_level = bright_r;
  assign out_glyph_index      = gid_r;
  assign out_glyph_bitmap     = bitmap_r;
  assign out_last             = last_r;

endmodule

`default_nettype wire

// ===== sv/display_command_byte_parser.sv =====
// Top level of the display command byte parser.
// The parser takes one command byte per cycle while its queue is not full and
// turns it into display actions: put character, set brightness and define
// glyph. The opcodes are the five configuration registers (set cursor, write
// run, brightness, define glyph, clear line); a byte in idle that matches none
// is dropped. Each byte is classified combinationally in the front end; bytes
// that cause results enter a four-entry command queue, and the back end drives
// a registered output, so a result passes through the queue and then the
// output register. A clear line command produces CLEAR_WIDTH put character
// results, one per cycle from the back end's clear counter while the output
// is not stalled; input bytes keep being taken meanwhile until the queue fills.
// out_last marks the final result of each input byte. The column wraps
// modulo 256.
`default_nettype none

module display_command_byte_parser
  import dcbp_pkg::*;
#(
  parameter int CLEAR_WIDTH = CLEAR_WIDTH_DEF,
  parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_action,
  output logic [7:0]                out_column,
  output logic [7:0]                out_char_code,
  output logic [7:0]                out_brightness_level,
  output logic [7:0]                out_glyph_index,
  output logic [63:0]               out_glyph_bitmap,
  output logic                      out_last
);

  logic in_accept;
  logic push, pop, full, head_valid;
  cmd_t push_cmd, head_cmd;

  assign in_ready  = !full;
  assign in_accept = in_valid && in_ready;

  dcbp_front #(
    .CLEAR_WIDTH(CLEAR_WIDTH),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_rx_byte(in_rx_byte),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dcbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  dcbp_back #(
    .CLEAR_WIDTH(CLEAR_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_cmd            (head_cmd),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_column          (out_column),
    .out_char_code       (out_char_code),
    .out_brightness_level(out_brightness_level),
    .out_glyph_index     (out_glyph_index),
    .out_glyph_bitmap    (out_glyph_bitmap),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/dcbp_checker.sv =====
// Port-level assertions for the display command byte parser and their bind.
`default_nettype none

module dcbp_checker
  import dcbp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_action,
  input wire logic [7:0]  out_column,
  input wire logic [7:0]  out_char_code,
  input wire logic [7:0]  out_brightness_level,
  input wire logic [7:0]  out_glyph_index,
  input wire logic [63:0] out_glyph_bitmap,
  input wire logic        out_last
);

  // A stalled result transaction must not be withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // Brightness and glyph actions each end the results of their byte.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_BRIGHT || out_action == ACT_GLYPH) |-> out_last)
    else $error("single-result action without last");

  // Fields that do not belong to an action read as zero.
  a_bright_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_BRIGHT |->
      out_column == 8'd0 && out_char_code == 8'd0 &&
      out_glyph_index == 8'd0 && out_glyph_bitmap == 64'd0)
    else $error("brightness result carries stray fields");

  a_put_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_PUT_CHAR |->
      out_brightness_level == 8'd0 && out_glyph_index == 8'd0 &&
      out_glyph_bitmap == 64'd0)
    else $error("put character result carries stray fields");

endmodule

bind display_command_byte_parser dcbp_checker u_dcbp_checker (.*);

`default_nettype wire

// ===== tb/display_command_byte_parser_tb.sv =====
// Self-checking testbench for the display command byte parser.
`timescale 1ns / 100ps

module display_command_byte_parser_tb
  import dcbp_pkg::*;
();

  localparam int CLEAR_W      = CLEAR_WIDTH_DEF;
  localparam int GLYPH_N      = GLYPH_ROWS_DEF;
  localparam int QUIET_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_BYTES  = 38;
  // No register sits at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  column;
    logic [7:0]  char_code;
    logic [7:0]  brightness;
    logic [7:0]  glyph_id;
    logic [63:0] bitmap;
    logic        last;
  } disp_action_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_action;
  logic [7:0]           out_column;
  logic [7:0]           out_char_code;
  logic [7:0]           out_brightness_level;
  logic [7:0]           out_glyph_index;
  logic [63:0]          out_glyph_bitmap;
  logic                 out_last;

  // Parser state as the display sees it, tracked per accepted byte.
  logic [7:0]   opcode [5] = '{OP_SET_CURSOR_RST, OP_WRITE_RUN_RST, OP_BRIGHTNESS_RST,
                               OP_DEFINE_GLYPH_RST, OP_CLEAR_LINE_RST};
  parse_state_t parse_st = ST_IDLE;
  logic [7:0]   cursor = 8'h00;
  logic [7:0]   chars_left = 8'h00;
  logic [7:0]   glyph_id = 8'h00;
  logic [7:0]   glyph_rows [MAX_ROWS];
  int           rows_seen = 0;

  disp_action_t display_actions [$];
  int           bad_actions = 0;
  int           bytes_used = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  int unsigned  rx_tick = 0;
  logic [1:0]   rx_mode = 2'd0;

  display_command_byte_parser #(
    .CLEAR_WIDTH(CLEAR_W),
    .GLYPH_ROWS (GLYPH_N)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_column          (out_column),
    .out_char_code       (out_char_code),
    .out_brightness_level(out_brightness_level),
    .out_glyph_index     (out_glyph_index),
    .out_glyph_bitmap    (out_glyph_bitmap),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void put_char(input logic [7:0] ch, input logic last);
    disp_action_t act;
    act = {ACT_PUT_CHAR, cursor, ch, 8'h00, 8'h00, 64'h0, last};
    display_actions.push_back(act);
    cursor = cursor + 8'd1;
  endfunction

  // Advances the parser by one byte and queues the display actions it causes.
  // Returns 0 for an idle byte that matches no opcode.
  function automatic bit decode_byte(input logic [7:0] b);
    disp_action_t act;
    logic [63:0]  bmp;
    decode_byte = 1'b1;
    case (parse_st)
      ST_IDLE: begin
        if (b == opcode[CFG_OP_SET_CURSOR]) parse_st = ST_CURSOR;
        else if (b == opcode[CFG_OP_WRITE_RUN]) parse_st = ST_COUNT;
        else if (b == opcode[CFG_OP_BRIGHTNESS]) parse_st = ST_BRIGHT;
        else if (b == opcode[CFG_OP_DEFINE_GLYPH]) parse_st = ST_GLYPH_ID;
        else if (b == opcode[CFG_OP_CLEAR_LINE]) parse_st = ST_CLEAR;
        else decode_byte = 1'b0;
      end
      ST_CURSOR: begin
        cursor = b;
        parse_st = ST_IDLE;
      end
      ST_COUNT: begin
        chars_left = b;
        parse_st = ST_CHARS;
      end
      ST_CHARS: begin
        put_char(b, 1'b1);
        // A count of zero wraps through 255 and so puts 256 characters.
        chars_left = chars_left - 8'd1;
        if (chars_left == 8'h00) parse_st = ST_IDLE;
      end
      ST_BRIGHT: begin
        act = {ACT_BRIGHT, 8'h00, 8'h00, b, 8'h00, 64'h0, 1'b1};
        display_actions.push_back(act);
        parse_st = ST_IDLE;
      end
      ST_GLYPH_ID: begin
        glyph_id = b;
        parse_st = ST_GLYPH_ROWS;
      end
      ST_GLYPH_ROWS: begin
        glyph_rows[rows_seen] = b;
        rows_seen++;
        if (rows_seen >= GLYPH_N) begin
          bmp = 64'h0;
          for (int i = 0; i < GLYPH_N; i++) bmp[8*i +: 8] = glyph_rows[i];
          act = {ACT_GLYPH, 8'h00, 8'h00, 8'h00, glyph_id, bmp, 1'b1};
          display_actions.push_back(act);
          rows_seen = 0;
          parse_st = ST_IDLE;
        end
      end
      default: begin
        cursor = 8'h00;
        for (int i = 0; i < CLEAR_W; i++) put_char(SPACE_CODE, i == CLEAR_W - 1);
        parse_st = ST_IDLE;
      end
    endcase
  endfunction

  function automatic string show(input disp_action_t a);
    return $sformatf("{action %0d col %0d char %02h bright %02h glyph %02h bitmap %016h last %0b}",
                     a.action, a.column, a.char_code, a.brightness, a.glyph_id, a.bitmap,
                     a.last);
  endfunction

  // The receiver picks a new stall pattern when rx_tick[5:0] is zero: always ready,
  // coin flips, a stall when rx_tick[2:0] is zero, or long stalls.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_tick[2:0] != 3'd0);
      default: out_ready <= (rx_tick[4:3] == 2'd0);
    endcase
  end

  always @(posedge clk) begin : check_actions
    disp_action_t got;
    disp_action_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_action, out_column, out_char_code, out_brightness_level, out_glyph_index,
             out_glyph_bitmap, out_last};
      if (display_actions.size() == 0) begin
        if (bad_actions < MAX_REPORTS) $display("unexpected action: %s", show(got));
        bad_actions++;
      end else begin
        want = display_actions.pop_front();
        if (got.action !== want.action || got.column !== want.column ||
            got.char_code !== want.char_code || got.brightness !== want.brightness ||
            got.glyph_id !== want.glyph_id || got.bitmap !== want.bitmap ||
            got.last !== want.last) begin
          if (bad_actions < MAX_REPORTS)
            $display("action mismatch: expected %s got %s", show(want), show(got));
          bad_actions++;
        end
      end
    end
  end

  // Sends one byte; the sender works in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    if (decode_byte(b)) bytes_used++;
  endtask

  task automatic wait_actions_done();
    in_valid <= 1'b0;
    while (display_actions.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Element i of vals goes to register i. Only called while the parser is quiet.
  task automatic load_opcodes(input logic [4:0][7:0] vals);
    for (int i = CFG_OP_SET_CURSOR; i <= CFG_OP_CLEAR_LINE; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      opcode[i] = vals[i];
    end
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_run(input logic [7:0] count);
    int n;
    n = (count == 8'h00) ? 256 : count;
    send_byte(opcode[CFG_OP_WRITE_RUN]);
    send_byte(count);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_glyph(input logic [7:0] id, input logic [63:0] bmp);
    send_byte(opcode[CFG_OP_DEFINE_GLYPH]);
    send_byte(id);
    for (int i = 0; i < GLYPH_N; i++) send_byte(bmp[8*i +: 8]);
  endtask

  // One well-formed command with random arguments, chosen by its register index.
  task automatic send_command(input logic [CFG_IDX_W-1:0] which);
    logic [7:0] count;
    case (which)
      CFG_OP_WRITE_RUN: begin
        count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 40))
                                            : 8'($urandom_range(1, 6));
        send_run(count);
      end
      CFG_OP_DEFINE_GLYPH: send_glyph(8'($urandom), {$urandom, $urandom});
      default: begin
        send_byte(opcode[which]);
        send_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic test_reset_opcodes();
    send_byte(8'h00);
    send_byte(8'h06);
    send_byte(8'hFF);
    send_byte(opcode[CFG_OP_BRIGHTNESS]);
    send_byte(8'h00);
    send_byte(opcode[CFG_OP_BRIGHTNESS]);
    send_byte(8'hFF);
    send_glyph(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_glyph(8'hFF, 64'h0000_0000_0000_0000);
    wait_actions_done();
  endtask

  // The column runs past 255 back to 0, and a clear leaves it at the clear width.
  task automatic test_column_wrap();
    send_byte(opcode[CFG_OP_SET_CURSOR]);
    send_byte(8'hFF);
    send_byte(opcode[CFG_OP_WRITE_RUN]);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(opcode[CFG_OP_CLEAR_LINE]);
    send_byte(8'hAA);
    send_run(8'd1);
    wait_actions_done();
  endtask

  task automatic test_count_zero();
    gaps_on = 1'b0;
    send_run(8'h00);
    wait_actions_done();
    gaps_on = 1'b1;
  endtask

  task automatic test_extreme_opcodes();
    load_opcodes({8'h01, 8'h7F, 8'h80, 8'hFF, 8'h00});
    for (int i = CFG_OP_SET_CURSOR; i <= CFG_OP_CLEAR_LINE; i++)
      send_command(CFG_IDX_W'(i));
    send_byte(8'h02);
    wait_actions_done();
  endtask

  // All opcodes share one value, then the winners move away one at a time so that
  // each command in the priority order gets its turn.
  task automatic test_equal_opcodes();
    logic [7:0]      shared;
    logic [4:0][7:0] vals;
    shared = 8'($urandom_range(16, 200));
    for (int k = CFG_OP_SET_CURSOR; k <= CFG_OP_CLEAR_LINE; k++) begin
      for (int j = CFG_OP_SET_CURSOR; j <= CFG_OP_CLEAR_LINE; j++)
        vals[j] = (j < k) ? shared + 8'(j + 1) : shared;
      load_opcodes(vals);
      send_command(CFG_IDX_W'(k));
      wait_actions_done();
    end
  endtask

  task automatic test_random_traffic();
    int pick;
    for (int p = 0; p < 4; p++) begin
      load_opcodes(40'({$urandom, $urandom}));
      gaps_on = (p != 2);
      bytes_used = 0;
      while (bytes_used < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_command(CFG_IDX_W'($urandom_range(CFG_OP_SET_CURSOR, CFG_OP_CLEAR_LINE)));
        end else if (pick < 90) begin
          send_byte(8'($urandom));
        end else begin
          // An opcode followed by another opcode that is taken as its argument.
          send_byte(opcode[$urandom_range(CFG_OP_SET_CURSOR, CFG_OP_CLEAR_LINE)]);
          send_byte(opcode[$urandom_range(CFG_OP_SET_CURSOR, CFG_OP_CLEAR_LINE)]);
        end
      end
      wait_actions_done();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_opcodes();
    test_column_wrap();
    test_count_zero();
    test_extreme_opcodes();
    test_equal_opcodes();
    test_random_traffic();
    if (bad_actions == 0 && display_actions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dcbp_pkg.sv
sv/dcbp_front.sv
sv/dcbp_queue.sv
sv/dcbp_back.sv
sv/display_command_byte_parser.sv
sv/dcbp_checker.sv
tb/display_command_byte_parser_tb.sv
